// File: rtl/lcm3_pkg.sv
package lcm3_pkg;

   // operand and result sizing
   localparam int OPERAND_BITS = 16;
   localparam int FIELD_BITS   = 16;
   localparam int MULT_BITS    = 48;
   localparam int WIDE_BITS    = 2 * OPERAND_BITS;
   localparam int SUB_BITS     = WIDE_BITS + 1;
   localparam int PROD_BITS    = 3 * OPERAND_BITS;
   localparam int COUNT_BITS   = $clog2(WIDE_BITS + 1);

   // input word
   typedef struct packed {
      logic [FIELD_BITS-1:0] first_operand;
      logic [FIELD_BITS-1:0] second_operand;
      logic [FIELD_BITS-1:0] third_operand;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [MULT_BITS-1:0] multiple;
      logic                 zero_error;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TWOS,
      ST_ODD,
      ST_DIV,
      ST_MUL
   } state_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic zero_in;
      logic u_even;
      logic v_even;
      logic same;
      logic ge;
      logic count_done;
   } status_type;

   // one-cycle actions for the datapath
   typedef struct packed {
      logic load;
      logic reject;
      logic twos_shift;
      logic half_u;
      logic half_v;
      logic sub_u;
      logic swap;
      logic div_init;
      logic div_step;
      logic div_mode;
      logic mul_pair;
      logic mul_final;
   } ctrl_type;

endpackage

// File: rtl/lcm3_sub.sv
module lcm3_sub import lcm3_pkg::*; (
   input  logic [SUB_BITS-1:0] x,
   input  logic [SUB_BITS-1:0] y,
   output logic [SUB_BITS-1:0] diff,
   output logic                ge,
   output logic                same
);

   logic borrow;

   // shared subtract with borrow, and equality compare
   assign {borrow, diff} = {1'b0, x} - {1'b0, y};
   assign ge   = ~borrow;
   assign same = (x == y);

endmodule

// File: rtl/lcm3_seq.sv
module lcm3_seq import lcm3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;
   logic      phase_ff, phase_in;

   // state and pair phase registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            phase_in = 1'b0;
            if (start && !status.zero_in) state_in = ST_TWOS;
         end
         ST_TWOS: begin
            if (!(status.u_even && status.v_even)) state_in = ST_ODD;
         end
         ST_ODD: begin
            if (!status.u_even && !status.v_even && status.same) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.count_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            phase_in = 1'b1;
            state_in = phase_ff ? ST_IDLE : ST_TWOS;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath actions
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load   = start & ~status.zero_in;
            ctrl.reject = start & status.zero_in;
         end
         ST_TWOS: begin
            ctrl.twos_shift = status.u_even & status.v_even;
         end
         ST_ODD: begin
            if (status.u_even)      ctrl.half_u   = 1'b1;
            else if (status.v_even) ctrl.half_v   = 1'b1;
            else if (status.same)   ctrl.div_init = 1'b1;
            else if (status.ge)     ctrl.sub_u    = 1'b1;
            else                    ctrl.swap     = 1'b1;
         end
         ST_DIV: begin
            ctrl.div_mode = 1'b1;
            ctrl.div_step = 1'b1;
         end
         ST_MUL: begin
            ctrl.mul_final = phase_ff;
            ctrl.mul_pair  = ~phase_ff;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/lcm_of_three.sv
// lcm_of_three: least common multiple of three unsigned operands.
//
// Input channel: drive req_word and raise start; the word is taken at the
// clock edge where start is high and busy is low. busy stays high while
// an item is being worked on, and no new word is taken meanwhile.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_word;
// the receiver must take it then, it cannot hold results off.
//
// The work is lcm(lcm(a, b), c). Each pair goes through a binary gcd on a
// single shared subtract/compare unit, then a restoring divide by the gcd
// (one quotient bit per cycle), then one multiply.
// Latency is data dependent, set mostly by the gcd subtract/shift loop
// and the two bit-serial divides. One item is in flight at a time.
// A zero operand is flagged: the result (multiple zero, zero_error set)
// comes out the cycle after accept.
// Reset is synchronous and returns the block to idle with no result
// pending; there is no stored state between items.
module lcm_of_three import lcm3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int W  = OPERAND_BITS;
   localparam int DW = WIDE_BITS;

   logic [DW-1:0]         u_ff, u_in;
   logic [DW-1:0]         v_ff, v_in;
   logic [DW-1:0]         n_ff, n_in;
   logic [DW-1:0]         r_ff, r_in;
   logic [W-1:0]          m_ff, m_in;
   logic [W-1:0]          c_ff, c_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;

   logic [W-1:0]          op_a, op_b, op_c;
   logic [SUB_BITS-1:0]   sub_x, sub_y, sub_diff;
   logic                  sub_ge, sub_same;
   logic [SUB_BITS-1:0]   rem_shift;
   logic [PROD_BITS-1:0]  prod;
   logic [DW-1:0]         pair_lcm;
   status_type            status;
   ctrl_type              ctrl;

   // operands cut to the used width
   assign op_a = W'(req_word.first_operand);
   assign op_b = W'(req_word.second_operand);
   assign op_c = W'(req_word.third_operand);

   // shared arithmetic unit inputs
   assign rem_shift = {r_ff, n_ff[DW-1]};
   assign sub_x     = ctrl.div_mode ? rem_shift : {1'b0, u_ff};
   assign sub_y     = ctrl.div_mode ? {1'b0, u_ff} : {1'b0, v_ff};

   lcm3_sub u_sub (
      .x    (sub_x),
      .y    (sub_y),
      .diff (sub_diff),
      .ge   (sub_ge),
      .same (sub_same)
   );

   // quotient times the other operand
   assign prod     = PROD_BITS'(n_ff) * PROD_BITS'(m_ff);
   assign pair_lcm = DW'(prod);

   // status for the sequencer
   always_comb begin
      status.zero_in    = (op_a == '0) || (op_b == '0) || (op_c == '0);
      status.u_even     = ~u_ff[0];
      status.v_even     = ~v_ff[0];
      status.same       = sub_same;
      status.ge         = sub_ge;
      status.count_done = (count_ff == COUNT_BITS'(DW - 1));
   end

   lcm3_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   // datapath next values
   always_comb begin
      u_in          = u_ff;
      v_in          = v_ff;
      n_in          = n_ff;
      r_in          = r_ff;
      m_in          = m_ff;
      c_in          = c_ff;
      count_in      = count_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_strobe_in = 1'b0;
      if (ctrl.load) begin
         u_in = DW'(op_a);
         v_in = DW'(op_b);
         n_in = DW'(op_a);
         m_in = op_b;
         c_in = op_c;
      end
      if (ctrl.reject) begin
         rsp_word_in.multiple   = '0;
         rsp_word_in.zero_error = 1'b1;
         rsp_strobe_in          = 1'b1;
      end
      // strip common factors of two, dividend follows
      if (ctrl.twos_shift) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         n_in = n_ff >> 1;
      end
      if (ctrl.half_u) u_in = u_ff >> 1;
      if (ctrl.half_v) v_in = v_ff >> 1;
      if (ctrl.sub_u)  u_in = sub_diff[DW-1:0];
      if (ctrl.swap) begin
         u_in = v_ff;
         v_in = u_ff;
      end
      if (ctrl.div_init) begin
         r_in     = '0;
         count_in = '0;
      end
      // restoring divide step, divisor is the odd part of the gcd held in u
      if (ctrl.div_step) begin
         r_in     = sub_ge ? sub_diff[DW-1:0] : rem_shift[DW-1:0];
         n_in     = {n_ff[DW-2:0], sub_ge};
         count_in = count_ff + 1'b1;
      end
      if (ctrl.mul_pair) begin
         u_in = pair_lcm;
         v_in = DW'(c_ff);
         n_in = pair_lcm;
         m_in = c_ff;
      end
      if (ctrl.mul_final) begin
         rsp_word_in.multiple   = MULT_BITS'(prod);
         rsp_word_in.zero_error = 1'b0;
         rsp_strobe_in          = 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      v_ff        <= v_in;
      n_ff        <= n_in;
      r_ff        <= r_in;
      m_ff        <= m_in;
      c_ff        <= c_in;
      count_ff    <= count_in;
      rsp_word_ff <= rsp_word_in;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import lcm3_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int DRAIN_CYCLES  = 300;
   localparam int PHASE_ITEMS   = 282;
   localparam int PHASE_COUNT   = 4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   req_word_type operand_queue[$];
   rsp_word_type lcm_expected[$];
   logic         taken = 1'b0;
   int unsigned  send_idle_pct = 0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;

   lcm_of_three dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // euclid on 64-bit values
   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // expected result word for one input word
   function automatic rsp_word_type lcm_of_word(req_word_type w);
      longint unsigned mask;
      longint unsigned a, b, c, ab, g;
      rsp_word_type    r;
      mask = (64'd1 << OPERAND_BITS) - 1;
      a = longint'(w.first_operand) & mask;
      b = longint'(w.second_operand) & mask;
      c = longint'(w.third_operand) & mask;
      r = '0;
      if (a == 0 || b == 0 || c == 0) begin
         r.zero_error = 1'b1;
         return r;
      end
      g  = gcd_of(a, b);
      ab = (a / g) * b;
      g  = gcd_of(ab, c);
      r.multiple = MULT_BITS'((ab / g) * c);
      return r;
   endfunction

   task automatic push_item(int unsigned a, int unsigned b, int unsigned c);
      req_word_type w;
      w.first_operand  = FIELD_BITS'(a);
      w.second_operand = FIELD_BITS'(b);
      w.third_operand  = FIELD_BITS'(c);
      operand_queue.push_back(w);
   endtask

   // one operand, often a multiple of a factor shared across the word
   function automatic int unsigned random_operand(int unsigned common);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 3)
         return 0;
      else if (pick < 8)
         return ($urandom_range(1) != 0) ? 65535 : 1;
      else if (pick < 35)
         return $urandom_range(65535);
      else if (pick < 50)
         return 1 << $urandom_range(15);
      else if (pick < 70)
         return common * $urandom_range(32, 1);
      else
         return common * $urandom_range(65535 / common, 1);
   endfunction

   task automatic random_item();
      int unsigned common;
      common = 1;
      if ($urandom_range(99) < 40)
         common = $urandom_range(255, 2);
      push_item(random_operand(common), random_operand(common), random_operand(common));
   endtask

   // checked at the rising edge, where start is stable
   task automatic wait_drained();
      while (operand_queue.size() != 0 || start || lcm_expected.size() != 0)
         @(posedge clock);
   endtask

   // driver: hold the word until taken, else offer the next one or idle
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         // word still waiting for the block
      end else if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_word <= operand_queue.pop_front();
         start    <= 1'b1;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check result words, record accepted input words
   always @(posedge clock) begin
      if (reset) begin
         taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (lcm_expected.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_word);
               error_count = error_count + 1;
            end else begin
               if (rsp_word.multiple !== lcm_expected[0].multiple) begin
                  $display("%0t: multiple expected %0d actual %0d", $time,
                           lcm_expected[0].multiple, rsp_word.multiple);
                  error_count = error_count + 1;
               end
               if (rsp_word.zero_error !== lcm_expected[0].zero_error) begin
                  $display("%0t: zero_error expected %0b actual %0b", $time,
                           lcm_expected[0].zero_error, rsp_word.zero_error);
                  error_count = error_count + 1;
               end
               void'(lcm_expected.pop_front());
            end
         end
         taken <= start && !busy;
         if (start && !busy)
            lcm_expected.push_back(lcm_of_word(req_word));
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** lcm_of_three: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned idle_plan[PHASE_COUNT];
      idle_plan = '{0, 51, 0, 25};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words: extremes, zero in each slot, shared and coprime factors
      push_item(1, 1, 1);
      push_item(65535, 65535, 65535);
      push_item(65535, 65534, 65533);
      push_item(65521, 65519, 65497);
      push_item(0, 5, 7);
      push_item(5, 0, 7);
      push_item(5, 7, 0);
      push_item(0, 0, 0);
      push_item(0, 65535, 65535);
      push_item(1, 65535, 1);
      push_item(32768, 16384, 1024);
      push_item(32768, 65535, 1);
      push_item(2, 3, 5);
      push_item(4, 6, 8);
      push_item(12, 18, 30);
      push_item(7, 7, 7);
      push_item(43690, 21845, 65535);
      push_item(255, 256, 257);
      push_item(1024, 59049, 15625);
      push_item(60060, 60060, 1);
      push_item(2, 2, 65535);
      wait_drained();

      // random phases, each starting with nothing outstanding
      for (int p = 0; p < PHASE_COUNT; p++) begin
         @(posedge clock);
         send_idle_pct = idle_plan[p];
         for (int i = 0; i < PHASE_ITEMS; i++)
            random_item();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("** lcm_of_three: PASSED **");
      else
         $display("** lcm_of_three: FAILED **");
      $finish;
   end

endmodule
